### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the fmp blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/fmp_pkg.sv
// ----------------------------------------------------------------------------
// fmp_pkg
// Types and constants of the first minimum parabolic finder.
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COORD_W  = 16;
  localparam int VAL_W    = 31;                 // clipped squared modulus
  localparam int REG_W    = 31;                 // widest config register
  localparam int CFG_IDX_W = 1;

  localparam int SQ_W   = 2 * SAMPLE_W;
  localparam int CMP_W  = (SQ_W > VAL_W) ? SQ_W : VAL_W;
  localparam int PROD_W = COORD_W + VAL_W;      // |dx| * |dg|
  localparam int MAC_W  = COORD_W + PROD_W;     // |dx|^2 * |dg|
  localparam int NUM_W  = MAC_W + 2;            // signed numerator
  localparam int DEN_W  = PROD_W + 2;           // signed denominator
  localparam int CNT_W  = $clog2(COORD_W);

  localparam int QUEUE_DEPTH = 2;

  localparam logic [REG_W-1:0] LIMIT_RESET = REG_W'(805306368);
  localparam logic [REG_W-1:0] LEVEL_RESET = REG_W'(268435456);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS_LIMIT = 1'b0,
    REG_MINIMUM_LEVEL = 1'b1
  } fmp_reg_e;

  typedef enum logic [3:0] {
    BE_IDLE,
    BE_PROD,
    BE_MUL,
    BE_SUM,
    BE_ABS,
    BE_CHECK,
    BE_OVF,
    BE_DIV,
    BE_ROUND,
    BE_OUT
  } fmp_be_state_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re_part;
    logic signed [SAMPLE_W-1:0] im_part;
    logic [COORD_W-1:0]         coord;
    logic                       last;
  } fmp_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] r0;
    logic               found;
  } fmp_out_t;

  // one entry per run: index 0 is the oldest window slot, 1 the center
  typedef struct packed {
    logic                        found;
    logic [2:0][VAL_W-1:0]       vals;
    logic [2:0][COORD_W-1:0]     coords;
  } fmp_job_t;

endpackage

### rtl/fmp_front.sv
// ----------------------------------------------------------------------------
// fmp_front
// Squares each sample, clips it and runs the four-sample minimum search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmp_front import fmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  fmp_in_t              in_data_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output fmp_job_t             q_job_o
);

  localparam logic [1:0] FILL_FULL = 2'd3;

  function automatic logic [SAMPLE_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] raw);
    return raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  endfunction

  logic [REG_W-1:0] limit_q, level_q;

  logic               a_valid_q;
  logic [SQ_W-1:0]    a_sq_re_q, a_sq_im_q;
  logic [COORD_W-1:0] a_coord_q;
  logic               a_last_q;

  logic [2:0][VAL_W-1:0]   win_val_q;
  logic [2:0][COORD_W-1:0] win_coord_q;
  logic [1:0]              fill_q;
  logic                    found_q;

  logic [SAMPLE_W-1:0] re_mag, im_mag;
  logic [SQ_W-1:0]     v_sum;
  logic [VAL_W-1:0]    v_clip;
  logic                in_fire, b_fire, find;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      level_q <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (fmp_reg_e'(cfg_idx_i))
        REG_MODULUS_LIMIT: limit_q <= cfg_data_i;
        REG_MINIMUM_LEVEL: level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // a last beat waits in stage a until the queue has room
  assign in_stall_o = a_valid_q & a_last_q & q_full_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign b_fire     = a_valid_q & ~in_stall_o;

  assign re_mag = sample_mag(in_data_i.re_part);
  assign im_mag = sample_mag(in_data_i.im_part);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_fire) begin
      a_valid_q <= 1'b1;
    end else if (b_fire) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_sq_re_q <= SQ_W'(re_mag) * SQ_W'(re_mag);
      a_sq_im_q <= SQ_W'(im_mag) * SQ_W'(im_mag);
      a_coord_q <= in_data_i.coord;
      a_last_q  <= in_data_i.last;
    end
  end

  assign v_sum  = a_sq_re_q + a_sq_im_q;
  assign v_clip = (CMP_W'(v_sum) > CMP_W'(limit_q)) ? '0 : VAL_W'(v_sum);

  assign find = ~found_q && (fill_q == FILL_FULL) && (win_val_q[2] > win_val_q[1]) &&
                (v_clip > win_val_q[1]) && (CMP_W'(win_val_q[1]) < CMP_W'(level_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      found_q <= 1'b0;
    end else if (b_fire) begin
      if (a_last_q) begin
        fill_q  <= '0;
        found_q <= 1'b0;
      end else if (find) begin
        found_q <= 1'b1;
      end else if (!found_q && fill_q != FILL_FULL) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // window freezes once a minimum is found
  always_ff @(posedge clk_i) begin
    if (b_fire && !found_q && !find) begin
      win_val_q   <= {v_clip, win_val_q[2], win_val_q[1]};
      win_coord_q <= {a_coord_q, win_coord_q[2], win_coord_q[1]};
    end
  end

  assign q_push_o       = b_fire & a_last_q;
  assign q_job_o.found  = found_q | find;
  assign q_job_o.vals   = win_val_q;
  assign q_job_o.coords = win_coord_q;

  `ASSERT_NEXT(a_run_clears, clk_i, rst_ni, b_fire && a_last_q, fill_q == '0 && !found_q, "run state not cleared after last beat")

endmodule

### rtl/fmp_queue.sv
// ----------------------------------------------------------------------------
// fmp_queue
// Short queue of finished runs between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmp_queue import fmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fmp_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output fmp_job_t job_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  fmp_job_t         mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, clk_i, rst_ni, !(push_i && full_o), "push into full queue")
  `ASSERT_ALWAYS(a_no_underflow, clk_i, rst_ni, !(pop_i && !valid_o), "pop from empty queue")

endmodule

### rtl/fmp_back.sv
// ----------------------------------------------------------------------------
// fmp_back
// Parabolic vertex of a found minimum: serial multiply and restoring divide.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fmp_back import fmp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  fmp_job_t q_job_i,
  output logic     q_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fmp_out_t out_data_o
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(COORD_W - 1);

  fmp_be_state_e state_q, state_d;

  logic [CNT_W-1:0]   cnt_q;
  logic [COORD_W-1:0] x0_q, d1m_q, d2m_q, mb1_q, mb2_q, quo_q;
  logic               d1n_q, d2n_q, g1n_q, g2n_q;
  logic [VAL_W-1:0]   g1m_q, g2m_q;
  logic [PROD_W-1:0]  p1_q, p2_q;
  logic [MAC_W-1:0]   mc1_q, mc2_q, acc1_q, acc2_q;
  logic [NUM_W-1:0]   num_q, rem_q, dsh_q;
  logic [DEN_W-1:0]   den_q, ad_q;
  logic               ovf_q, qneg_q, dzero_q;
  fmp_out_t           res_q;

  // difference and magnitude terms of the window
  logic [COORD_W:0]   dx1, dx2, dx1_neg, dx2_neg;
  logic [VAL_W:0]     dg1, dg2, dg1_neg, dg2_neg;
  logic [PROD_W-1:0]  prod1, prod2;
  logic [NUM_W-1:0]   t1, t2, dsh_next;
  logic [DEN_W-1:0]   u1, u2;
  logic [COORD_W:0]   up_sum, dn_diff;
  logic [COORD_W-1:0] r0_d;
  logic               div_ge;

  always_comb begin
    dx1 = {1'b0, q_job_i.coords[1]} - {1'b0, q_job_i.coords[0]};
    dx2 = {1'b0, q_job_i.coords[1]} - {1'b0, q_job_i.coords[2]};
    dg1 = {1'b0, q_job_i.vals[1]} - {1'b0, q_job_i.vals[2]};
    dg2 = {1'b0, q_job_i.vals[1]} - {1'b0, q_job_i.vals[0]};
    dx1_neg = '0 - dx1;
    dx2_neg = '0 - dx2;
    dg1_neg = '0 - dg1;
    dg2_neg = '0 - dg2;
  end

  assign prod1 = PROD_W'(d1m_q) * PROD_W'(g1m_q);
  assign prod2 = PROD_W'(d2m_q) * PROD_W'(g2m_q);

  // num = dx1^2*g1 - dx2^2*g2, den = dx1*g1 - dx2*g2
  assign t1 = g1n_q ? (NUM_W'(0) - NUM_W'(acc1_q)) : NUM_W'(acc1_q);
  assign t2 = g2n_q ? (NUM_W'(0) - NUM_W'(acc2_q)) : NUM_W'(acc2_q);
  assign u1 = (d1n_q ^ g1n_q) ? (DEN_W'(0) - DEN_W'(p1_q)) : DEN_W'(p1_q);
  assign u2 = (d2n_q ^ g2n_q) ? (DEN_W'(0) - DEN_W'(p2_q)) : DEN_W'(p2_q);

  assign dsh_next = dsh_q >> 1;
  assign div_ge   = (rem_q >= dsh_next);

  assign up_sum  = {1'b0, x0_q} + {1'b0, quo_q};
  assign dn_diff = {1'b0, x0_q} - {1'b0, quo_q};

  always_comb begin
    if (dzero_q) begin
      r0_d = x0_q;
    end else if (ovf_q) begin
      r0_d = qneg_q ? '1 : '0;
    end else if (qneg_q) begin
      r0_d = up_sum[COORD_W] ? '1 : up_sum[COORD_W-1:0];
    end else begin
      r0_d = dn_diff[COORD_W] ? '0 : dn_diff[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    q_pop_o     = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      BE_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = q_job_i.found ? BE_PROD : BE_OUT;
        end
      end
      BE_PROD:  state_d = BE_MUL;
      BE_MUL: begin
        if (cnt_q == LAST_STEP) begin
          state_d = BE_SUM;
        end
      end
      BE_SUM:   state_d = BE_ABS;
      BE_ABS:   state_d = BE_CHECK;
      BE_CHECK: state_d = dzero_q ? BE_ROUND : BE_OVF;
      BE_OVF:   state_d = BE_DIV;
      BE_DIV: begin
        if (cnt_q == LAST_STEP) begin
          state_d = BE_ROUND;
        end
      end
      BE_ROUND: state_d = BE_OUT;
      BE_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = BE_IDLE;
        end
      end
      default:  state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      BE_IDLE: begin
        if (q_valid_i) begin
          x0_q  <= q_job_i.coords[1];
          d1n_q <= dx1[COORD_W];
          d2n_q <= dx2[COORD_W];
          g1n_q <= dg1[VAL_W];
          g2n_q <= dg2[VAL_W];
          d1m_q <= dx1[COORD_W] ? dx1_neg[COORD_W-1:0] : dx1[COORD_W-1:0];
          d2m_q <= dx2[COORD_W] ? dx2_neg[COORD_W-1:0] : dx2[COORD_W-1:0];
          g1m_q <= dg1[VAL_W] ? dg1_neg[VAL_W-1:0] : dg1[VAL_W-1:0];
          g2m_q <= dg2[VAL_W] ? dg2_neg[VAL_W-1:0] : dg2[VAL_W-1:0];
          res_q <= '0;
        end
      end
      BE_PROD: begin
        p1_q   <= prod1;
        p2_q   <= prod2;
        mc1_q  <= MAC_W'(prod1);
        mc2_q  <= MAC_W'(prod2);
        mb1_q  <= d1m_q;
        mb2_q  <= d2m_q;
        acc1_q <= '0;
        acc2_q <= '0;
        cnt_q  <= '0;
      end
      BE_MUL: begin
        // shift-add, one multiplier bit per cycle in both lanes
        if (mb1_q[0]) begin
          acc1_q <= acc1_q + mc1_q;
        end
        if (mb2_q[0]) begin
          acc2_q <= acc2_q + mc2_q;
        end
        mc1_q <= mc1_q << 1;
        mc2_q <= mc2_q << 1;
        mb1_q <= mb1_q >> 1;
        mb2_q <= mb2_q >> 1;
        cnt_q <= cnt_q + 1'b1;
      end
      BE_SUM: begin
        num_q <= t1 - t2;
        den_q <= u1 - u2;
      end
      BE_ABS: begin
        rem_q   <= num_q[NUM_W-1] ? (NUM_W'(0) - num_q) : num_q;
        ad_q    <= den_q[DEN_W-1] ? (DEN_W'(0) - den_q) : den_q;
        dzero_q <= (den_q == '0);
        qneg_q  <= num_q[NUM_W-1] ^ den_q[DEN_W-1];
      end
      BE_CHECK: begin
        // round half away from zero: (|num| + |den|) / (2 |den|)
        rem_q <= rem_q + NUM_W'(ad_q);
        dsh_q <= NUM_W'(ad_q) << (COORD_W + 1);
      end
      BE_OVF: begin
        ovf_q <= (rem_q >= dsh_q);
        quo_q <= '0;
        cnt_q <= '0;
      end
      BE_DIV: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh_next;
        end
        quo_q <= {quo_q[COORD_W-2:0], div_ge};
        dsh_q <= dsh_next;
        cnt_q <= cnt_q + 1'b1;
      end
      BE_ROUND: begin
        res_q.found <= 1'b1;
        res_q.r0    <= r0_d;
      end
      default: ;
    endcase
  end

  assign out_data_o = res_q;

  `ASSERT_SAME(a_none_is_zero, clk_i, rst_ni, out_valid_o && !out_data_o.found, out_data_o.r0 == '0, "run without minimum gives nonzero r0")
  `ASSERT_NEXT(a_single_beat, clk_i, rst_ni, out_valid_o && !out_stall_i, !out_valid_o, "result delivered twice")

endmodule

### rtl/first_minimum_parabolic_finder.sv
// ----------------------------------------------------------------------------
// first_minimum_parabolic_finder
// First local minimum of squared modulus with parabolic vertex per run.
// ----------------------------------------------------------------------------
//  channel | dir | signals
//  --------+-----+--------------------------------------------
//  in      | in  | in_valid_i, in_stall_o, in_data_i (fmp_in_t)
//  out     | out | out_valid_o, out_stall_i, out_data_o (fmp_out_t)
//  cfg     | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
//  the front end takes one sample beat per cycle while not stalled; two
//  pipeline stages (square, then clip and window search) sit ahead of a
//  two-run queue. in the back end a run with a minimum passes the bit-serial
//  multiply and, for a nonzero divisor, the restoring divide; a run without
//  one skips both. a last beat stalls input only while the queue is full.
//  reset is asynchronous active low and clears control state; no clearing pass.
// ----------------------------------------------------------------------------
module first_minimum_parabolic_finder import fmp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [REG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  fmp_in_t              in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fmp_out_t             out_data_o
);

  logic     q_push, q_full, q_pop, q_valid;
  fmp_job_t q_job_in, q_job_out;

  fmp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_job_o    (q_job_in)
  );

  fmp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job_out)
  );

  fmp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

### bench/first_minimum_parabolic_finder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_minimum_parabolic_finder_tb
// Self-checking bench: streams runs of complex samples through the finder,
// predicts the first qualifying minimum and its parabolic vertex per run,
// and compares every result beat against the prediction under five
// register settings and four idling patterns.
// ----------------------------------------------------------------------------
module first_minimum_parabolic_finder_tb import fmp_pkg::*; ();

  localparam int LATENCY_PAUSE = 64;   // back end worst case plus pipeline
  localparam logic signed [127:0] Q_CAP = 128'sd1 <<< 34;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_MODULUS_LIMIT;
  logic [REG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  fmp_in_t              in_data = '0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  fmp_out_t             out_data;

  // stimulus and expectations
  fmp_in_t  sample_feed[$];
  fmp_out_t pending_minima[$];
  logic     in_taken = 1'b0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       calm_left = 0;

  // predictor state
  logic [REG_W-1:0] limit_cfg = LIMIT_RESET;
  logic [REG_W-1:0] level_cfg = LEVEL_RESET;
  longint           win_val[3];
  longint           win_crd[3];
  int               win_fill;
  bit               run_hit;
  logic [COORD_W-1:0] run_pos;

  int errors = 0;
  int beats_taken = 0;
  int runs_done = 0;
  int minima_seen = 0;

  always #5 clk = ~clk;

  first_minimum_parabolic_finder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_data_i   (in_data),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_window();
    for (int i = 0; i < 3; i++) begin
      win_val[i] = 0;
      win_crd[i] = 0;
    end
    win_fill = 0;
    run_hit  = 1'b0;
    run_pos  = '0;
  endtask

  // vertex of the parabola through prev, center and next, rounded half away
  function automatic logic [COORD_W-1:0] vertex_of_window();
    logic signed [127:0] dx1, dx2, g1, g2, num, den, an, ad, q;
    longint r;
    dx1 = win_crd[1] - win_crd[0];
    dx2 = win_crd[1] - win_crd[2];
    g1  = win_val[1] - win_val[2];
    g2  = win_val[1] - win_val[0];
    num = dx1 * dx1 * g1 - dx2 * dx2 * g2;
    den = dx1 * g1 - dx2 * g2;
    if (den == 0) return COORD_W'(win_crd[1]);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q  = (an + ad) / (ad + ad);
    if (q > Q_CAP) q = Q_CAP;
    if ((num < 0) != (den < 0)) r = win_crd[1] + longint'(q);
    else r = win_crd[1] - longint'(q);
    if (r < 0) return '0;
    if (r > longint'({COORD_W{1'b1}})) return '1;
    return COORD_W'(r);
  endfunction

  task automatic take_sample(input fmp_in_t s);
    longint re, im, v;
    fmp_out_t res;
    re = longint'(s.re_part);
    im = longint'(s.im_part);
    v  = re * re + im * im;
    if (v > longint'(limit_cfg)) v = 0;
    if (!run_hit) begin
      if (win_fill >= 3 && win_val[2] > win_val[1] && v > win_val[1] &&
          win_val[1] < longint'(level_cfg)) begin
        run_pos = vertex_of_window();
        run_hit = 1'b1;
      end else begin
        win_val[0] = win_val[1];
        win_val[1] = win_val[2];
        win_val[2] = v;
        win_crd[0] = win_crd[1];
        win_crd[1] = win_crd[2];
        win_crd[2] = longint'(s.coord);
        if (win_fill < 3) win_fill++;
      end
    end
    if (s.last) begin
      res.r0    = run_hit ? run_pos : '0;
      res.found = run_hit;
      pending_minima.push_back(res);
      clear_window();
    end
  endtask

  task automatic check_result(input fmp_out_t got);
    fmp_out_t want;
    if (pending_minima.size() == 0) begin
      report_mismatch($sformatf("unexpected result r0=%0d found=%0b", got.r0, got.found));
    end else begin
      want = pending_minima.pop_front();
      if (got.found !== want.found)
        report_mismatch($sformatf("found %0b, predicted %0b", got.found, want.found));
      if (got.r0 !== want.r0)
        report_mismatch($sformatf("r0 %0d, predicted %0d", got.r0, want.r0));
      runs_done++;
      if (want.found) minima_seen++;
    end
  endtask

  // sample beats and result beats are both taken at the rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        take_sample(in_data);
        beats_taken++;
      end
      if (out_valid && !out_stall) check_result(out_data);
    end
  end

  // driver: new beats and stall decisions at the falling edge
  always @(negedge clk) begin
    if (calm_left > 0) begin
      calm_left <= calm_left - 1;
    end else if ($urandom_range(0, 47) == 0) begin
      calm_left <= $urandom_range(10, 40);
    end
    out_stall <= rst_n && calm_left == 0 && $urandom_range(0, 99) < stall_pct;
    if (rst_n && (!in_valid || in_taken)) begin
      if (sample_feed.size() > 0 && (calm_left != 0 || $urandom_range(0, 99) >= idle_pct)) begin
        in_valid <= 1'b1;
        in_data  <= sample_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic fmp_in_t beat(input int re, input int im, input int crd, input bit last);
    fmp_in_t s;
    s.re_part = re[SAMPLE_W-1:0];
    s.im_part = im[SAMPLE_W-1:0];
    s.coord   = crd[COORD_W-1:0];
    s.last    = last;
    return s;
  endfunction

  task automatic write_reg(input fmp_reg_e idx, input logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODULUS_LIMIT: limit_cfg = val;
      REG_MINIMUM_LEVEL: level_cfg = val;
      default: ;
    endcase
  endtask

  // one run: mostly a noisy valley, sometimes pure noise or a short run
  task automatic queue_run(input int amp_max, input int eq_re, input int eq_im,
                           output int len);
    int k, floor_a, step, amp, re, im, crd, cstep, cmode, dist_k;
    bit noisy;
    noisy = $urandom_range(0, 99) < 15;
    if (noisy) len = $urandom_range(1, 8);
    else if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 3);
    else len = $urandom_range(4, 10);
    k       = $urandom_range(0, len - 1);
    floor_a = $urandom_range(0, amp_max / 2);
    step    = $urandom_range(1, amp_max / 3 + 1);
    cmode   = $urandom_range(0, 9);
    crd     = $urandom_range(0, 65535);
    cstep   = $urandom_range(1, 3000);
    for (int i = 0; i < len; i++) begin
      if (noisy) begin
        re  = int'($urandom);
        im  = int'($urandom);
        crd = int'($urandom);
      end else begin
        dist_k = (i > k) ? i - k : k - i;
        amp = floor_a + step * dist_k + $urandom_range(0, step / 2);
        if (amp > 32767) amp = 32767;
        re = amp;
        im = $urandom_range(0, amp / 4);
        // a sample sitting exactly on the modulus limit
        if (eq_re != 0 && $urandom_range(0, 7) == 0) begin
          re = eq_re;
          im = eq_im;
        end
        if ($urandom_range(0, 1)) re = -re;
        if ($urandom_range(0, 1)) im = -im;
        if (i > 0) begin
          if (cmode < 7) crd = crd + cstep;
          else if (cmode > 7) crd = $urandom_range(0, 65535);
        end
      end
      sample_feed.push_back(beat(re, im, crd, i == len - 1));
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_feed.size() != 0 || in_valid || pending_minima.size() != 0);
    // all predicted results are in; the pause catches any result beyond them
    repeat (LATENCY_PAUSE) @(negedge clk);
  endtask

  task automatic run_phase(input bit do_cfg, input logic [REG_W-1:0] lim,
                           input logic [REG_W-1:0] lvl, input int eq_re, input int eq_im,
                           input int amp_max, input int idle, input int stall,
                           input int n_items);
    int queued, len;
    if (do_cfg) begin
      write_reg(REG_MODULUS_LIMIT, lim);
      write_reg(REG_MINIMUM_LEVEL, lvl);
    end
    idle_pct  = idle;
    stall_pct = stall;
    queued = 0;
    while (queued < n_items) begin
      queue_run(amp_max, eq_re, eq_im, len);
      queued += len;
    end
    wait_drained();
  endtask

  initial begin
    clear_window();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single-sample run
    sample_feed.push_back(beat(100, -200, 300, 1'b1));
    // clean minimum, later samples of the run ignored
    sample_feed.push_back(beat(12000, 0, 1000, 1'b0));
    sample_feed.push_back(beat(-4000, 0, 2000, 1'b0));
    sample_feed.push_back(beat(8000, 0, 3000, 1'b0));
    sample_feed.push_back(beat(0, -10000, 4000, 1'b0));
    sample_feed.push_back(beat(0, 0, 5000, 1'b0));
    sample_feed.push_back(beat(-32768, -32768, 6000, 1'b1));
    // vertex beyond the top of the coordinate range
    sample_feed.push_back(beat(2, 2, 60000, 1'b0));
    sample_feed.push_back(beat(0, 0, 65000, 1'b0));
    sample_feed.push_back(beat(1, 0, 64000, 1'b0));
    sample_feed.push_back(beat(3, 0, 100, 1'b1));
    // vertex below zero
    sample_feed.push_back(beat(-2, 2, 5535, 1'b0));
    sample_feed.push_back(beat(0, 0, 535, 1'b0));
    sample_feed.push_back(beat(0, -1, 1535, 1'b0));
    sample_feed.push_back(beat(0, 3, 65535, 1'b1));
    // equal coordinates give a zero divisor
    sample_feed.push_back(beat(3, 0, 5000, 1'b0));
    sample_feed.push_back(beat(0, 0, 5000, 1'b0));
    sample_feed.push_back(beat(1, 0, 5000, 1'b0));
    sample_feed.push_back(beat(2, 0, 5000, 1'b1));
    // full-scale samples clipped to zero; the next one clips too, so no minimum
    sample_feed.push_back(beat(8000, 0, 100, 1'b0));
    sample_feed.push_back(beat(-32768, -32768, 200, 1'b0));
    sample_feed.push_back(beat(0, 8000, 300, 1'b0));
    sample_feed.push_back(beat(32767, 32767, 400, 1'b1));
    // dip in the last two samples never counts
    sample_feed.push_back(beat(10000, 0, 10, 1'b0));
    sample_feed.push_back(beat(9000, 0, 20, 1'b0));
    sample_feed.push_back(beat(1000, 0, 30, 1'b0));
    sample_feed.push_back(beat(5000, 0, 40, 1'b1));

    run_phase(1'b0, LIMIT_RESET, LEVEL_RESET, 0, 0, 30000, 0, 0, 300);
    run_phase(1'b1, 31'd169000000, 31'h7FFF_FFFF, 12000, 5000, 14000, 64, 0, 300);
    run_phase(1'b1, 31'h7FFF_FFFF, 31'h0800_0000, 0, 0, 32767, 0, 64, 300);
    run_phase(1'b1, 31'd0, 31'd0, 0, 0, 2000, 30, 30, 100);
    run_phase(1'b1, 31'd500000000, 31'd400000000, 20000, 10000, 24000, 30, 30, 300);

    $display("covered %0d sample beats in %0d runs, %0d of them with a minimum,",
             beats_taken, runs_done, minima_seen);
    $display("under five register settings and four idling patterns");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending_minima.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
